@@ sv/ppdp_pkg.sv @@
// shared types, constants and helpers for the point/plane distance, projection and reflection block
// no dependencies
`default_nettype none

package ppdp_pkg;

  localparam int CW        = 32;        // coordinate and coefficient width, Q16.16
  localparam int FB        = 16;        // fraction bits
  localparam int TOL_W     = 16;
  localparam int DIST_W    = CW - 1;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 2 * CW;    // one coefficient times one coordinate, also |n|^2
  localparam int NUM_W     = 3 * CW;    // |n_i| * |n.p + d|
  localparam int QUO_W     = 40;        // offset quotient bits, offset capped at 2^QUO_W
  localparam int OFF_W     = QUO_W + 1;
  localparam int EXT_W     = OFF_W + 2; // room for p - 2*offset
  localparam int CAP_W     = PROD_W + QUO_W;
  localparam int LANES     = 4;         // three offset lanes and the distance lane

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A = 3'd0,
    REG_COEF_B = 3'd1,
    REG_COEF_C = 3'd2,
    REG_COEF_D = 3'd3,
    REG_TOL    = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]    distance;
    logic                 on_plane;
    logic signed [CW-1:0] proj_x;
    logic signed [CW-1:0] proj_y;
    logic signed [CW-1:0] proj_z;
    logic signed [CW-1:0] mirror_x;
    logic signed [CW-1:0] mirror_y;
    logic signed [CW-1:0] mirror_z;
    logic                 degenerate;
  } out_item_t;

  // data that rides along the divider stages
  typedef struct packed {
    logic [2:0][CW-1:0] p;
    logic [2:0]         sn;    // sign of n_i * t
    logic [2:0]         cap;   // offset quotient at or above the cap
    logic               dsat;  // distance quotient above the output range
  } side_t;

  localparam int SIDE_W = $bits(side_t);

  function automatic logic [CW-1:0] mag(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [CW-1:0] sat_ext(input logic [EXT_W-1:0] v);
    if (v[EXT_W-1:CW-1] == {(EXT_W-CW+1){v[EXT_W-1]}}) begin
      return v[CW-1:0];
    end else if (v[EXT_W-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/ppdp_if.sv @@
// valid/ready channel interfaces for point items and result items
// depends on ppdp_pkg
`default_nettype none

interface ppdp_in_if import ppdp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppdp_out_if import ppdp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/point_plane_distance_project_reflect.sv @@
// top level: plane registers, |n|^2 and |n| sequencer, item pipeline and output skid buffer
// depends on ppdp_pkg, ppdp_if and ppdp_div
//
// Each point gives one result: distance to the plane a*x+b*y+c*z+d=0, on-plane flag, orthogonal
// projection and mirror image in Q16.16, the distance unsigned with 16 fraction bits, all
// saturated. The block takes one point per clock while in_ch.ready is high: seven arithmetic
// stages form n.p+d and the numerators, then a 40-stage restoring divider produces one
// quotient bit per stage for the three offsets and the distance together, then the output
// register. After reset and after every configuration write, in_ch.ready stays low while a
// sequencer forms |n|^2 with one multiplier and takes its square root one bit per cycle. A
// stalled output holds one more result in a skid register before the pipeline stops.
`default_nettype none

module point_plane_distance_project_reflect import ppdp_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CW-1:0]        cfg_data,
  ppdp_in_if.sink                   in_ch,
  ppdp_out_if.source                out_ch
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUMSQ,
    ST_ROOT,
    ST_FLAGS,
    ST_IDLE
  } seq_st_t;

  // ---------------- configuration registers
  logic [CW-1:0]    coef_r [4];
  logic [TOL_W-1:0] tol_r;
  logic [CW-1:0]    cmag_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= '0;
      coef_r[1] <= '0;
      coef_r[2] <= CW'(1) << FB;
      coef_r[3] <= '0;
      tol_r     <= TOL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_COEF_A: coef_r[0] <= cfg_data;
        REG_COEF_B: coef_r[1] <= cfg_data;
        REG_COEF_C: coef_r[2] <= cfg_data;
        REG_COEF_D: coef_r[3] <= cfg_data;
        REG_TOL:    tol_r     <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      cmag_r[i] <= mag(coef_r[i]);
    end
  end

  // ---------------- |n|^2 and |n| sequencer
  seq_st_t          st_r;
  logic [4:0]       cnt_r;
  logic [PROD_W-1:0] prod_r, l2_r, sh_r;
  logic [CW+1:0]    rem_r;
  logic [CW-1:0]    len_r;
  logic             degen_r, flat_r;

  logic [CW+3:0] rt, trial, rt_sub;
  logic          rt_ge;

  always_comb begin
    rt     = {rem_r, sh_r[PROD_W-1 -: 2]};
    trial  = {2'b00, len_r, 2'b01};
    rt_ge  = rt >= trial;
    rt_sub = rt - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_LOAD;
      cnt_r <= '0;
    end else if (cfg_we) begin
      st_r <= ST_LOAD;
    end else begin
      unique case (st_r)
        ST_LOAD: begin
          cnt_r <= '0;
          l2_r  <= '0;
          st_r  <= ST_SUMSQ;
        end
        ST_SUMSQ: begin
          if (cnt_r != 5'd0) begin
            l2_r <= l2_r + prod_r;
          end
          if (cnt_r[1:0] != 2'd3) begin
            prod_r <= PROD_W'(cmag_r[cnt_r[1:0]]) * PROD_W'(cmag_r[cnt_r[1:0]]);
            cnt_r  <= cnt_r + 5'd1;
          end else begin
            sh_r  <= l2_r + prod_r;
            rem_r <= '0;
            len_r <= '0;
            cnt_r <= '0;
            st_r  <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          // two bits of |n|^2 per step, one bit of |n|
          rem_r <= rt_ge ? rt_sub[CW+1:0] : rt[CW+1:0];
          len_r <= {len_r[CW-2:0], rt_ge};
          sh_r  <= sh_r << 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd31) begin
            st_r <= ST_FLAGS;
          end
        end
        ST_FLAGS: begin
          degen_r <= (len_r == '0) || (len_r < CW'(tol_r));
          flat_r  <= (l2_r == '0) || (l2_r < (PROD_W'(tol_r) << FB));
          st_r    <= ST_IDLE;
        end
        ST_IDLE: ;
        default: st_r <= ST_LOAD;
      endcase
    end
  end

  // ---------------- item pipeline
  logic pipe_en, acc;
  logic skid_v_r, out_v_r;
  out_item_t skid_d_r, out_d_r;

  assign pipe_en     = !skid_v_r;
  assign in_ch.ready = pipe_en && (st_r == ST_IDLE) && !cfg_we;
  assign acc         = in_ch.valid && in_ch.ready;

  logic a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r;
  logic [CW-1:0]     a_p_r [3], a_pm_r [3];
  logic [CW-1:0]     b_p_r [3], c_p_r [3], d_p_r [3], e_p_r [3], f_p_r [3], g_p_r [3];
  logic [PROD_W-1:0] b_prod_r [3];
  logic [2:0]        b_sg_r;
  logic [PROD_W-1:0] c_pos_r, c_neg_r;
  logic [PROD_W-1:0] d_nmag_r, e_nmag_r, f_nmag_r, g_nmag_r;
  logic              d_nneg_r, e_nneg_r, f_nneg_r;
  logic [PROD_W-1:0] e_pl_r [3], e_ph_r [3];
  logic [NUM_W-1:0]  f_n_r [3], g_n_r [3];
  logic [2:0]        g_sn_r, g_cap_r;
  logic              g_dsat_r;

  logic [PROD_W-1:0] pos_nxt, neg_nxt, dterm;

  always_comb begin
    dterm   = PROD_W'(cmag_r[3]) << FB;
    pos_nxt = coef_r[3][CW-1] ? '0 : dterm;
    neg_nxt = coef_r[3][CW-1] ? dterm : '0;
    for (int i = 0; i < 3; i++) begin
      if (b_sg_r[i]) begin
        neg_nxt = neg_nxt + b_prod_r[i];
      end else begin
        pos_nxt = pos_nxt + b_prod_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r} <= '0;
    end else if (pipe_en) begin
      {a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r, g_v_r} <=
        {acc, a_v_r, b_v_r, c_v_r, d_v_r, e_v_r, f_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_p_r[0] <= in_ch.data.point_x;
      a_p_r[1] <= in_ch.data.point_y;
      a_p_r[2] <= in_ch.data.point_z;
      a_pm_r[0] <= mag(in_ch.data.point_x);
      a_pm_r[1] <= mag(in_ch.data.point_y);
      a_pm_r[2] <= mag(in_ch.data.point_z);
      for (int i = 0; i < 3; i++) begin
        b_prod_r[i] <= PROD_W'(cmag_r[i]) * PROD_W'(a_pm_r[i]);
        b_sg_r[i]   <= coef_r[i][CW-1] ^ a_p_r[i][CW-1];
        e_pl_r[i]   <= PROD_W'(cmag_r[i]) * PROD_W'(d_nmag_r[CW-1:0]);
        e_ph_r[i]   <= PROD_W'(cmag_r[i]) * PROD_W'(d_nmag_r[PROD_W-1:CW]);
        f_n_r[i]    <= (NUM_W'(e_ph_r[i]) << CW) + NUM_W'(e_pl_r[i]);
        g_n_r[i]    <= f_n_r[i];
        g_cap_r[i]  <= CAP_W'(f_n_r[i]) >= (CAP_W'(l2_r) << QUO_W);
        g_sn_r[i]   <= coef_r[i][CW-1] ^ f_nneg_r;
        b_p_r[i] <= a_p_r[i];
        c_p_r[i] <= b_p_r[i];
        d_p_r[i] <= c_p_r[i];
        e_p_r[i] <= d_p_r[i];
        f_p_r[i] <= e_p_r[i];
        g_p_r[i] <= f_p_r[i];
      end
      c_pos_r  <= pos_nxt;
      c_neg_r  <= neg_nxt;
      d_nneg_r <= c_neg_r > c_pos_r;
      d_nmag_r <= (c_neg_r > c_pos_r) ? (c_neg_r - c_pos_r) : (c_pos_r - c_neg_r);
      e_nmag_r <= d_nmag_r;
      e_nneg_r <= d_nneg_r;
      f_nmag_r <= e_nmag_r;
      f_nneg_r <= e_nneg_r;
      g_nmag_r <= f_nmag_r;
      g_dsat_r <= NUM_W'(f_nmag_r) >= (NUM_W'(len_r) << DIST_W);
    end
  end

  // ---------------- divider
  logic [NUM_W-1:0]  div_num [LANES];
  logic [PROD_W-1:0] div_den [LANES];
  logic [QUO_W-1:0]  div_quo [LANES];
  logic              div_v;
  side_t             sd_in, sd_out;
  logic [SIDE_W-1:0] div_side_o;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_num[i]  = g_n_r[i];
      div_den[i]  = l2_r;
      sd_in.p[i]  = g_p_r[i];
    end
    div_num[3]   = NUM_W'(g_nmag_r);
    div_den[3]   = PROD_W'(len_r);
    sd_in.sn     = g_sn_r;
    sd_in.cap    = g_cap_r;
    sd_in.dsat   = g_dsat_r;
  end

  ppdp_div #(
    .LANES (LANES),
    .NW    (NUM_W),
    .DW    (PROD_W),
    .QW    (QUO_W),
    .SW    (SIDE_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .in_v   (g_v_r),
    .num    (div_num),
    .den    (div_den),
    .side   (sd_in),
    .out_v  (div_v),
    .quo    (div_quo),
    .side_o (div_side_o)
  );

  assign sd_out = side_t'(div_side_o);

  // ---------------- result
  out_item_t        res;
  logic [CW-1:0]    pr_s [3], mi_s [3];
  logic [DIST_W-1:0] dist_val;

  always_comb begin
    logic [OFF_W-1:0] off;
    logic [EXT_W-1:0] pe, offe, soff;
    for (int i = 0; i < 3; i++) begin
      off  = sd_out.cap[i] ? (OFF_W'(1) << QUO_W) : OFF_W'(div_quo[i]);
      offe = EXT_W'(off);
      soff = sd_out.sn[i] ? (~offe + 1'b1) : offe;
      pe   = {{(EXT_W-CW){sd_out.p[i][CW-1]}}, sd_out.p[i]};
      if (flat_r) begin
        pr_s[i] = sd_out.p[i];
        mi_s[i] = sd_out.p[i];
      end else begin
        pr_s[i] = sat_ext(pe - soff);
        mi_s[i] = sat_ext(pe - {soff[EXT_W-2:0], 1'b0});
      end
    end
    if (degen_r) begin
      dist_val = '0;
    end else if (sd_out.dsat) begin
      dist_val = {DIST_W{1'b1}};
    end else begin
      dist_val = div_quo[3][DIST_W-1:0];
    end
    res.distance   = dist_val;
    res.on_plane   = dist_val < DIST_W'(tol_r);
    res.proj_x     = pr_s[0];
    res.proj_y     = pr_s[1];
    res.proj_z     = pr_s[2];
    res.mirror_x   = mi_s[0];
    res.mirror_y   = mi_s[1];
    res.mirror_z   = mi_s[2];
    res.degenerate = degen_r;
  end

  // ---------------- output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_ch.ready) begin
      if (div_v && pipe_en) begin
        skid_v_r <= 1'b1;
        skid_d_r <= res;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      out_d_r  <= skid_d_r;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= div_v && pipe_en;
      out_d_r <= res;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_d_r;

  // ---------------- checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while the output register is empty");

  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ch.ready)
    else $error("input accepted right after a configuration write");

  a_degen_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.data.degenerate) |-> (out_ch.data.distance == '0))
    else $error("degenerate normal with nonzero distance");

  a_on_plane: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.on_plane == (out_ch.data.distance < DIST_W'(tol_r))))
    else $error("on_plane flag disagrees with distance");

endmodule

`default_nettype wire

@@ sv/ppdp_div.sv @@
// pipelined restoring divider, one quotient bit per stage, several lanes sharing one valid
// divisors must be held steady by the caller (not enforced here); standalone, no package
`default_nettype none

module ppdp_div #(
  parameter int LANES = 4,
  parameter int NW    = 96,
  parameter int DW    = 64,
  parameter int QW    = 40,
  parameter int SW    = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_v,
  input  wire logic [NW-1:0] num [LANES],
  input  wire logic [DW-1:0] den [LANES],
  input  wire logic [SW-1:0] side,
  output logic               out_v,
  output logic [QW-1:0]      quo [LANES],
  output logic [SW-1:0]      side_o
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_r   [QW];
  logic [NW-1:0] rem_r [QW][LANES];
  logic [QW-1:0] q_r   [QW][LANES];
  logic [SW-1:0] sd_r  [QW];

  for (genvar s = 0; s < QW; s++) begin : g_st
    localparam int K = QW - 1 - s;

    logic          pv;
    logic [SW-1:0] psd;
    logic [NW-1:0] prem [LANES];
    logic [QW-1:0] pq   [LANES];
    logic [XW-1:0] tr   [LANES];
    logic          ge   [LANES];

    if (s == 0) begin : g_src
      always_comb begin
        pv  = in_v;
        psd = side;
        for (int l = 0; l < LANES; l++) begin
          prem[l] = num[l];
          pq[l]   = '0;
        end
      end
    end else begin : g_src
      always_comb begin
        pv  = v_r[s-1];
        psd = sd_r[s-1];
        for (int l = 0; l < LANES; l++) begin
          prem[l] = rem_r[s-1][l];
          pq[l]   = q_r[s-1][l];
        end
      end
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        tr[l] = XW'(den[l]) << K;
        ge[l] = XW'(prem[l]) >= tr[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[s] <= psd;
        for (int l = 0; l < LANES; l++) begin
          rem_r[s][l] <= ge[l] ? (prem[l] - tr[l][NW-1:0]) : prem[l];
          q_r[s][l]   <= pq[l] | (QW'(ge[l]) << K);
        end
      end
    end
  end

  always_comb begin
    out_v  = v_r[QW-1];
    side_o = sd_r[QW-1];
    for (int l = 0; l < LANES; l++) begin
      quo[l] = q_r[QW-1][l];
    end
  end

endmodule

`default_nettype wire
